// ===== design/qvnp_pkg.sv =====
// Shared types and constants for the QUIC version negotiation parser.
package qvnp_pkg;

  // Longest connection ID accepted in either length field
  localparam int unsigned MAX_ID_LEN       = 20;
  localparam logic [7:0]  MAX_VERSIONS_RST = 8'd16;
  localparam logic [2:0]  SHORT_PKT_LEN    = 3'd7;
  localparam int unsigned QUEUE_DEPTH      = 4;

  typedef enum logic [2:0] {
    PH_FIRST    = 3'd0,
    PH_VERSION  = 3'd1,
    PH_DCID_LEN = 3'd2,
    PH_DCID     = 3'd3,
    PH_SCID_LEN = 3'd4,
    PH_SCID     = 3'd5,
    PH_VERSIONS = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DCID   = 2'd0,
    KIND_SCID   = 2'd1,
    KIND_VER    = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARSE = 2'd1,
    ST_LEN   = 2'd2
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [7:0]  element_index;
    status_t     status;
    logic [7:0]  ver_total;
    logic        end_of_run;
  } result_t;

  // Results produced by one byte: count, then first and second word
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== design/quic_version_negotiation_parser_unit.sv =====
// An accepted word is held in the input register; when the queue has room, the parser writes
// its results into the four-entry result queue. Throughput: one input word per cycle while
//   each word yields at most one result and the receiver takes them; a final byte that also
//   closes an ID byte or version word yields two results, drained one per cycle.
// Reset: synchronous, active low; clears packet state and queue, the version word limit
//   returns to 16.
module quic_version_negotiation_parser_unit
  import qvnp_pkg::*;
#(
  parameter int unsigned ID_LEN_MAX = MAX_ID_LEN
)
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration: version word limit
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [31:0] value, [39:32] element_index, [41:40] status,
                                  // [49:42] ver_total, [55:50] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // end_of_run
);

  // Input register: one word waiting for the parser
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  logic       room2;
  logic       go;
  push_t      push;
  result_t    out_res;

  // Process the held word only when the queue can take both possible results
  assign go        = in_vld_r && room2;
  // Advance the input register whenever it is empty or being consumed this cycle
  assign in_tready = !in_vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  // Payload needs no reset; hold it while stalled
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  qvnp_parser #(
    .ID_LEN_MAX (ID_LEN_MAX)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go          (go),
    .in_byte     (in_byte_r),
    .in_last     (in_last_r),
    .push        (push)
  );

  qvnp_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the head result onto the stream fields
  assign out_tdata = {6'd0, out_res.ver_total, out_res.status,
                      out_res.element_index, out_res.value};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.end_of_run;

endmodule

// ===== design/qvnp_parser.sv =====
// Per-byte packet state update and result generation.
module qvnp_parser
  import qvnp_pkg::*;
#(
  parameter int unsigned ID_LEN_MAX = MAX_ID_LEN
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       go,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output push_t      push
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  field_position_r, field_position_nxt;
  logic [7:0]  id_bytes_left_r, id_bytes_left_nxt;
  logic [23:0] word_assembly_r, word_assembly_nxt;
  logic [7:0]  words_emitted_r, words_emitted_nxt;
  status_t     error_code_r, error_code_nxt;
  logic [2:0]  short_count_r, short_count_nxt;
  logic [7:0]  word_limit_r;

  // Packet view after this byte, before the end-of-packet clear
  phase_t      pkt_phase;
  logic [7:0]  pkt_field_position;
  logic [7:0]  pkt_words;
  status_t     pkt_error;
  logic [2:0]  pkt_short;
  logic        id_len_bad;

  logic        item_v;
  result_t     item;
  result_t     stat;
  status_t     final_st;

  assign id_len_bad = (in_byte > 8'(ID_LEN_MAX));

  // Next state
  always_comb begin
    pkt_phase          = phase_r;
    pkt_field_position = field_position_r;
    id_bytes_left_nxt  = id_bytes_left_r;
    word_assembly_nxt  = word_assembly_r;
    pkt_words          = words_emitted_r;
    pkt_error          = error_code_r;
    pkt_short          = (short_count_r < SHORT_PKT_LEN) ? short_count_r + 3'd1 : short_count_r;

    if (error_code_r == ST_OK) begin
      case (phase_r)
        PH_FIRST: begin
          if (!in_byte[7]) begin
            pkt_error = ST_PARSE;
          end else begin
            pkt_phase          = PH_VERSION;
            pkt_field_position = 8'd0;
          end
        end
        PH_VERSION: begin
          if (in_byte != 8'd0) begin
            pkt_error = ST_PARSE;
          end else if (field_position_r >= 8'd3) begin
            pkt_phase          = PH_DCID_LEN;
            pkt_field_position = 8'd0;
          end else begin
            pkt_field_position = field_position_r + 8'd1;
          end
        end
        PH_DCID_LEN, PH_SCID_LEN: begin
          if (id_len_bad) begin
            pkt_error = ST_LEN;
          end else if (in_byte == 8'd0) begin
            pkt_phase          = (phase_r == PH_DCID_LEN) ? PH_SCID_LEN : PH_VERSIONS;
            pkt_field_position = 8'd0;
            word_assembly_nxt  = 24'd0;
          end else begin
            id_bytes_left_nxt  = in_byte;
            pkt_field_position = 8'd0;
            pkt_phase          = (phase_r == PH_DCID_LEN) ? PH_DCID : PH_SCID;
          end
        end
        PH_DCID, PH_SCID: begin
          pkt_field_position = field_position_r + 8'd1;
          id_bytes_left_nxt  = id_bytes_left_r - 8'd1;
          if (id_bytes_left_r == 8'd1) begin
            pkt_phase          = (phase_r == PH_DCID) ? PH_SCID_LEN : PH_VERSIONS;
            pkt_field_position = 8'd0;
            word_assembly_nxt  = 24'd0;
          end
        end
        PH_VERSIONS: begin
          if (field_position_r < 8'd3) begin
            word_assembly_nxt  = {word_assembly_r[15:0], in_byte};
            pkt_field_position = field_position_r + 8'd1;
          end else begin
            pkt_field_position = 8'd0;
            word_assembly_nxt  = 24'd0;
            if (words_emitted_r < word_limit_r) begin
              pkt_words = words_emitted_r + 8'd1;
            end
          end
        end
        default: begin
          pkt_error = ST_PARSE;
        end
      endcase
    end

    phase_nxt          = pkt_phase;
    field_position_nxt = pkt_field_position;
    words_emitted_nxt  = pkt_words;
    error_code_nxt     = pkt_error;
    short_count_nxt    = pkt_short;

    // Drop all packet state after the final byte
    if (in_last) begin
      phase_nxt          = PH_FIRST;
      field_position_nxt = 8'd0;
      id_bytes_left_nxt  = 8'd0;
      word_assembly_nxt  = 24'd0;
      words_emitted_nxt  = 8'd0;
      error_code_nxt     = ST_OK;
      short_count_nxt    = 3'd0;
    end
  end

  // Outputs
  always_comb begin
    item_v = 1'b0;
    item   = '0;
    if (error_code_r == ST_OK) begin
      case (phase_r)
        PH_DCID, PH_SCID: begin
          item_v             = 1'b1;
          item.kind          = (phase_r == PH_DCID) ? KIND_DCID : KIND_SCID;
          item.value         = {24'd0, in_byte};
          item.element_index = field_position_r;
        end
        PH_VERSIONS: begin
          if ((field_position_r >= 8'd3) && (words_emitted_r < word_limit_r)) begin
            item_v             = 1'b1;
            item.kind          = KIND_VER;
            item.value         = {word_assembly_r, in_byte};
            item.element_index = words_emitted_r;
          end
        end
        default: begin
          item_v = 1'b0;
        end
      endcase
    end
    item.end_of_run = !in_last;

    if (pkt_short < SHORT_PKT_LEN) begin
      final_st = ST_PARSE;
    end else if (pkt_error != ST_OK) begin
      final_st = pkt_error;
    end else if ((pkt_phase == PH_VERSIONS) && (pkt_field_position == 8'd0)) begin
      final_st = ST_OK;
    end else begin
      final_st = ST_PARSE;
    end

    stat            = '0;
    stat.kind       = KIND_STATUS;
    stat.status     = final_st;
    stat.ver_total  = pkt_words;
    stat.end_of_run = 1'b1;

    push = '0;
    if (go) begin
      push.n  = {1'b0, item_v} + {1'b0, in_last};
      push.r0 = item_v ? item : stat;
      push.r1 = stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_FIRST;
      field_position_r <= 8'd0;
      id_bytes_left_r  <= 8'd0;
      word_assembly_r  <= 24'd0;
      words_emitted_r  <= 8'd0;
      error_code_r     <= ST_OK;
      short_count_r    <= 3'd0;
      word_limit_r     <= MAX_VERSIONS_RST;
    end else begin
      if (go) begin
        phase_r          <= phase_nxt;
        field_position_r <= field_position_nxt;
        id_bytes_left_r  <= id_bytes_left_nxt;
        word_assembly_r  <= word_assembly_nxt;
        words_emitted_r  <= words_emitted_nxt;
        error_code_r     <= error_code_nxt;
        short_count_r    <= short_count_nxt;
      end
      if (cfg_wr_en) begin
        word_limit_r <= cfg_wr_data;
      end
    end
  end

`ifndef SYNTH
  a_id_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DCID || phase_r == PH_SCID) |-> (id_bytes_left_r != 8'd0))
    else $error("ID phase with no bytes left");

  a_word_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_VERSIONS) |-> (field_position_r < 8'd4))
    else $error("version word position out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (go && in_last) |=> (phase_r == PH_FIRST && words_emitted_r == 8'd0 &&
                         error_code_r == ST_OK && short_count_r == 3'd0))
    else $error("packet state not cleared after final byte");
`endif

endmodule

// ===== design/qvnp_result_queue.sv =====
// Small result queue: takes up to two words per cycle, gives one while out_ready is high.
module qvnp_result_queue
  import qvnp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room2,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (count_r <= CNT_W'(QUEUE_DEPTH - 2));
  assign count_nxt = count_r + CNT_W'(push.n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> ((count_r + CNT_W'(push.n)) <= CNT_W'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(wr_ptr_r - rd_ptr_r) == count_r[PTR_W-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== sim/quic_version_negotiation_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the QUIC version negotiation parser, byte stream in, results out.
module quic_version_negotiation_parser_unit_tb;
  import qvnp_pkg::*;

  localparam int LONG_HOLD = 120;   // receiver hold-off long enough to back up the input
  localparam int N_PHASES  = 7;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'd0;  // [7:0] in_byte
  logic        in_tlast    = 1'b0;  // last_byte
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [55:0] out_tdata;           // [31:0] value, [39:32] element_index, [41:40] status,
                                    // [49:42] ver_total, [55:50] zero
  logic [1:0]  out_tuser;           // [1:0] kind
  logic        out_tlast;           // end_of_run

  quic_version_negotiation_parser_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // Shared bookkeeping. Everything the posedge monitor updates is read only at
  // the falling edge, so no reader races the monitor.
  // ---------------------------------------------------------------------------
  logic [8:0] tx_bytes[$];          // {last, byte} words waiting for the driver
  result_t    expected_results[$];  // predicted results, oldest first
  int         bytes_queued   = 0;
  int         bytes_accepted = 0;
  int         packets_queued = 0;
  int         mismatches     = 0;
  int         kind_seen[4]   = '{0, 0, 0, 0};
  int         status_seen[4] = '{0, 0, 0, 0};
  int         long_holds     = 0;
  logic       in_taken       = 1'b0;  // input word accepted at the last rising edge
  int         in_idle_pct    = 0;
  int         out_idle_pct   = 0;
  logic       long_hold_ok   = 1'b1;

  // ---------------------------------------------------------------------------
  // Parser model: per-packet state and the version word limit register
  // ---------------------------------------------------------------------------
  phase_t      pr_phase;
  logic [7:0]  pr_pos;
  logic [7:0]  pr_left;
  logic [23:0] pr_acc;
  logic [7:0]  pr_words;
  status_t     pr_err;
  logic [2:0]  pr_short;
  logic [7:0]  pr_max = MAX_VERSIONS_RST;

  function automatic void clear_packet_model();
    pr_phase = PH_FIRST;
    pr_pos   = 8'd0;
    pr_left  = 8'd0;
    pr_acc   = 24'd0;
    pr_words = 8'd0;
    pr_err   = ST_OK;
    pr_short = 3'd0;
  endfunction

  function automatic result_t mk_result(kind_t k, logic [31:0] v, logic [7:0] idx,
                                        status_t s, logic [7:0] cnt);
    result_t r;
    r.kind          = k;
    r.value         = v;
    r.element_index = idx;
    r.status        = s;
    r.ver_total     = cnt;
    r.end_of_run    = 1'b0;
    return r;
  endfunction

  // Advance the model by one byte and queue the results it causes.
  function automatic void predict_byte_results(logic [7:0] b, logic last);
    result_t     outs[$];
    status_t     st;
    logic [31:0] word;
    if (pr_short < SHORT_PKT_LEN) pr_short++;
    // Once an error is latched, bytes are swallowed until the final one.
    if (pr_err == ST_OK) begin
      case (pr_phase)
        PH_FIRST: begin
          if (!b[7]) pr_err = ST_PARSE;
          else begin
            pr_phase = PH_VERSION;
            pr_pos   = 8'd0;
          end
        end
        PH_VERSION: begin
          if (b != 8'd0) pr_err = ST_PARSE;
          else if (pr_pos == 8'd3) begin
            pr_phase = PH_DCID_LEN;
            pr_pos   = 8'd0;
          end else pr_pos++;
        end
        PH_DCID_LEN, PH_SCID_LEN: begin
          if (b > MAX_ID_LEN) pr_err = ST_LEN;
          else if (b == 8'd0) begin
            pr_phase = (pr_phase == PH_DCID_LEN) ? PH_SCID_LEN : PH_VERSIONS;
            pr_pos   = 8'd0;
            pr_acc   = 24'd0;
          end else begin
            pr_left  = b;
            pr_pos   = 8'd0;
            pr_phase = (pr_phase == PH_DCID_LEN) ? PH_DCID : PH_SCID;
          end
        end
        PH_DCID, PH_SCID: begin
          outs.push_back(mk_result((pr_phase == PH_DCID) ? KIND_DCID : KIND_SCID,
                                   {24'd0, b}, pr_pos, ST_OK, 8'd0));
          pr_pos++;
          pr_left--;
          if (pr_left == 8'd0) begin
            pr_phase = (pr_phase == PH_DCID) ? PH_SCID_LEN : PH_VERSIONS;
            pr_pos   = 8'd0;
            pr_acc   = 24'd0;
          end
        end
        PH_VERSIONS: begin
          if (pr_pos < 8'd3) begin
            pr_acc = {pr_acc[15:0], b};
            pr_pos++;
          end else begin
            word   = {pr_acc, b};
            pr_pos = 8'd0;
            pr_acc = 24'd0;
            // Words past the limit are still aligned but neither emitted nor counted
            if (pr_words < pr_max) begin
              outs.push_back(mk_result(KIND_VER, word, pr_words, ST_OK, 8'd0));
              pr_words++;
            end
          end
        end
        default: pr_err = ST_PARSE;
      endcase
    end
    if (last) begin
      // A short packet is a parse error whatever else was seen; a clean packet
      // must end on a word boundary inside the version list.
      st = pr_err;
      if (pr_short < SHORT_PKT_LEN) st = ST_PARSE;
      else if (st == ST_OK && !(pr_phase == PH_VERSIONS && pr_pos == 8'd0)) st = ST_PARSE;
      outs.push_back(mk_result(KIND_STATUS, 32'd0, 8'd0, st, pr_words));
      clear_packet_model();
    end
    if (outs.size() > 0) outs[outs.size()-1].end_of_run = 1'b1;
    foreach (outs[i]) expected_results.push_back(outs[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input word, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        predict_byte_results(in_tdata, in_tlast);
        bytes_accepted++;
      end
      if (out_tvalid && out_tready) begin
        got.kind          = kind_t'(out_tuser);
        got.value         = out_tdata[31:0];
        got.element_index = out_tdata[39:32];
        got.status        = status_t'(out_tdata[41:40]);
        got.ver_total     = out_tdata[49:42];
        got.end_of_run    = out_tlast;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d value %h", got.kind,
                                    got.value));
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind: want %0d got %0d", want.kind, got.kind));
          if (got.value !== want.value)
            report_mismatch($sformatf("value: want %h got %h", want.value, got.value));
          if (got.element_index !== want.element_index)
            report_mismatch($sformatf("element_index: want %0d got %0d",
                                      want.element_index, got.element_index));
          if (got.status !== want.status)
            report_mismatch($sformatf("status: want %0d got %0d", want.status, got.status));
          if (got.ver_total !== want.ver_total)
            report_mismatch($sformatf("ver_total: want %0d got %0d",
                                      want.ver_total, got.ver_total));
          if (got.end_of_run !== want.end_of_run)
            report_mismatch($sformatf("end_of_run: want %0b got %0b",
                                      want.end_of_run, got.end_of_run));
          kind_seen[int'(want.kind)]++;
          if (want.kind == KIND_STATUS) status_seen[int'(want.status)]++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: hold a word until it is taken, then advance; random idle bursts
  // ---------------------------------------------------------------------------
  int in_gap = 0;

  always @(negedge clk) begin : drive_in
    logic [8:0] nxt;
    logic       v;
    nxt = {in_tlast, in_tdata};
    v   = in_tvalid;
    if (!rst_n) begin
      v = 1'b0;
    end else if (!(in_tvalid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        v = 1'b0;
      end else if (tx_bytes.size() == 0) begin
        v = 1'b0;
      end else if ($urandom_range(0, 99) < in_idle_pct) begin
        in_gap = $urandom_range(0, 10);
        v = 1'b0;
      end else begin
        nxt = tx_bytes.pop_front();
        v   = 1'b1;
      end
    end
    in_tvalid            <= v;
    {in_tlast, in_tdata} <= nxt;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off at fixed points of the
  // run so the result queue fills and the input backs up.
  // ---------------------------------------------------------------------------
  int out_gap      = 0;
  int hold_left    = 0;
  int next_hold_at = 300;

  always @(negedge clk) begin : drive_out
    logic r;
    r = 1'b1;
    if (!rst_n) begin
      r = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      r = 1'b0;
    end else if (long_hold_ok && bytes_accepted >= next_hold_at) begin
      hold_left    = LONG_HOLD - 1;
      next_hold_at = next_hold_at + 800;
      long_holds++;
      r = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      r = 1'b0;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      out_gap = $urandom_range(0, 10);
      r = 1'b0;
    end
    out_tready <= r;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic last);
    tx_bytes.push_back({last, b});
    bytes_queued++;
    if (last) packets_queued++;
  endtask

  // Queue n bytes of a packet given most significant byte first.
  task automatic queue_hex(input logic [127:0] data, input int n);
    for (int i = 0; i < n; i++) queue_byte(data[8*(n-1-i) +: 8], i == n - 1);
  endtask

  // Connection-ID length leaning toward the ends of its range
  function automatic int id_len();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 0;
    if (k == 1) return MAX_ID_LEN;
    return $urandom_range(0, MAX_ID_LEN);
  endfunction

  // Build one packet: well-formed with random content, or (when words is not
  // forced) now and then broken in one of several ways.
  task automatic queue_packet(input int force_words);
    logic [7:0]  pkt[$];
    logic [31:0] w;
    int          dlen, slen, nw, cut;
    pkt.push_back({1'b1, 7'($urandom)});
    repeat (4) pkt.push_back(8'h00);
    dlen = id_len();
    pkt.push_back(8'(dlen));
    repeat (dlen) pkt.push_back(8'($urandom));
    slen = id_len();
    pkt.push_back(8'(slen));
    repeat (slen) pkt.push_back(8'($urandom));
    if (force_words >= 0) nw = force_words;
    else if ($urandom_range(0, 3) == 0)
      nw = $urandom_range(0, (pr_max > 10) ? 12 : int'(pr_max) + 2);
    else nw = $urandom_range(0, 4);
    repeat (nw) begin
      case ($urandom_range(0, 5))
        0:       w = 32'd0;
        1:       w = '1;
        default: w = $urandom;
      endcase
      pkt.push_back(w[31:24]);
      pkt.push_back(w[23:16]);
      pkt.push_back(w[15:8]);
      pkt.push_back(w[7:0]);
    end
    if (force_words < 0 && $urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 5))
        0: pkt[0] = pkt[0] & 8'h7F;                                 // top bit clear
        1: pkt[$urandom_range(1, 4)] = 8'($urandom_range(1, 255));  // nonzero version
        2: pkt[$urandom_range(0, 1) ? 5 : 6 + dlen] =
             8'($urandom_range(MAX_ID_LEN + 1, 255));               // oversized ID length
        3: begin                                                    // truncated
          cut = $urandom_range(1, pkt.size() - 1);
          while (pkt.size() > cut) void'(pkt.pop_back());
        end
        4: repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom)); // partial trailing word
        default: begin                                              // noise
          pkt.delete();
          repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
        end
      endcase
    end
    foreach (pkt[i]) queue_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Sender side pause: wait until every queued word was taken and every
  // predicted result came back, then let the pipeline settle.
  task automatic wait_drained(input int settle);
    do @(negedge clk);
    while (bytes_accepted != bytes_queued || expected_results.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // Per phase: version word limit, idle percentage and random byte budget. The
  // limit 255 phase carries one long version list; the last phase runs flat out.
  int mv_plan[N_PHASES]     = '{16, 0, 1, 255, 0, 0, 3};
  int idle_plan[N_PHASES]   = '{20, 35, 0, 15, 50, 25, 0};
  int budget_plan[N_PHASES] = '{160, 180, 180, 60, 180, 180, 180};

  initial begin : stimulus
    int phase_start;
    clear_packet_model();
    mv_plan[4] = $urandom_range(2, 254);
    mv_plan[5] = $urandom_range(2, 254);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        // Register writes only with the block idle
        wait_drained(8);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 8'(mv_plan[p]);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        pr_max       = 8'(mv_plan[p]);
      end
      in_idle_pct  = idle_plan[p];
      out_idle_pct = idle_plan[p];
      long_hold_ok = (p != N_PHASES - 1);

      if (p == 0) begin
        // IDs of one byte each and one all-ones version word closing on the
        // last byte, so that byte yields a word and the status
        queue_hex(128'hFF_00_00_00_00_01_FF_01_00_FF_FF_FF_FF, 13);
        queue_hex(128'h7F, 1);                        // lone byte, top bit clear
        queue_hex(128'h80_00_00_00_00_FF_00, 7);      // oversized destination ID
        queue_hex(128'h80_00_00_00_00_15, 6);         // short packet hides a length error
      end
      if (p == 3) queue_packet(100);                  // long list, reaches high indexes

      phase_start = bytes_queued;
      while (bytes_queued - phase_start < budget_plan[p]) queue_packet(-1);
    end

    wait_drained(20);
    $display("Covered %0d packets, %0d bytes; %0d dest-ID, %0d source-ID, %0d version results.",
             packets_queued, bytes_accepted, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("Status ok/parse/length: %0d/%0d/%0d; %0d long receiver hold-offs.",
             status_seen[0], status_seen[1], status_seen[2], long_holds);
    if (mismatches == 0) begin
      $display("** quic_version_negotiation_parser_unit: PASSED **");
    end else begin
      $display("** quic_version_negotiation_parser_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("** quic_version_negotiation_parser_unit: FAILED **");
    $finish;
  end

endmodule

// ===== quic_version_negotiation_parser_unit.f =====
design/qvnp_pkg.sv
design/qvnp_parser.sv
design/qvnp_result_queue.sv
design/quic_version_negotiation_parser_unit.sv
sim/quic_version_negotiation_parser_unit_tb.sv
